/* hdl/bmrs_pkg.sv */
package bmrs_pkg;

    localparam int WORD_BITS     = 32;
    localparam int NUM_WORDS_DEF = 1024;
    localparam int SIZE_W        = 11;
    localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

    localparam int FUNC_W  = 2;
    localparam int START_W = 15;
    localparam int COUNT_W = 16;
    localparam int FBIT_W  = 16;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET    = 2'd0,
        FN_CLR    = 2'd1,
        FN_FIND   = 2'd2,
        FN_CLRALL = 2'd3
    } t_func;

    localparam logic PREG_SIZE = 1'b0;

endpackage

/* hdl/bitmap_range_set_clear_find.sv */
// Bitmap of NUM_WORDS 32-bit words with range set, range clear, find-first-set
// and clear-all commands; one result item per command item. After reset the
// block clears the whole bitmap, one word per cycle, and accepts no item until
// that is done. For a set, clear or find, one read-modify-write unit walks the
// range a word per cycle, reads overlapped with the update of the previous
// word; a find stops at the first word with a hit. Clear-all writes every word
// with zero before its result is valid. A range error or a zero count answers
// in the cycle after the accept.
// A new item is taken only once the previous result has been delivered.
// size_words is written over the APB port at address 0 and bounds the range
// check to min(size_words, NUM_WORDS) * 32 bits.
module bitmap_range_set_clear_find #(
    parameter int NUM_WORDS = bmrs_pkg::NUM_WORDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] func, [16:2] start_bit, [32:17] bit_count, [39:33] zero
    input  logic [bmrs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] found, [16:1] found_bit, [17] range_error, [23:18] zero
    output logic [bmrs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmrs_pkg::PADDR_W-1:0]       paddr,
    input  logic [bmrs_pkg::PDATA_W-1:0]       pwdata,
    output logic [bmrs_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LIM_W  = 22;
    localparam int WCNT_W = LIM_W - 5;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_CLR  = 5'b00100,
        S_WALK = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [bmrs_pkg::SIZE_W-1:0]  r_size;
    logic [bmrs_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [4:0]                   r_lo, n_lo;
    logic [4:0]                   r_hi, n_hi;
    logic [AW-1:0]                r_first, n_first;
    logic [AW-1:0]                r_last, n_last;
    logic [AW-1:0]                r_rdw, n_rdw;
    logic                         r_more, n_more;
    logic                         r_pv, n_pv;
    logic [AW-1:0]                r_pw, n_pw;
    logic                         r_found, n_found;
    logic [bmrs_pkg::FBIT_W-1:0]  r_fbit, n_fbit;
    logic                         r_err, n_err;

    logic [bmrs_pkg::WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [bmrs_pkg::WORD_BITS-1:0] r_rdata;

    // input fields
    logic [bmrs_pkg::FUNC_W-1:0]  in_func;
    logic [bmrs_pkg::START_W-1:0] in_start;
    logic [bmrs_pkg::COUNT_W-1:0] in_count;
    logic [bmrs_pkg::COUNT_W:0]   in_end;
    logic [bmrs_pkg::COUNT_W:0]   in_endm1;
    logic [WCNT_W-1:0]            lim_words;
    logic [LIM_W-1:0]             limit;
    logic                         in_err;
    logic                         s_acc;

    // shared update unit
    logic [bmrs_pkg::WORD_BITS-1:0] mask;
    logic [4:0]                     lo_sel;
    logic [4:0]                     hi_sel;
    logic [bmrs_pkg::WORD_BITS-1:0] hit;
    logic [bmrs_pkg::WORD_BITS-1:0] iso;
    logic [4:0]                     hit_idx;
    logic                           rd_en;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [bmrs_pkg::WORD_BITS-1:0] wr_data;
    logic                           cfg_wr;

    assign in_func  = i_s_tdata[1:0];
    assign in_start = i_s_tdata[16:2];
    assign in_count = i_s_tdata[32:17];
    assign in_end   = 17'(in_start) + 17'(in_count);
    assign in_endm1 = in_end - 17'd1;

    assign lim_words = (WCNT_W'(r_size) < WCNT_W'(NUM_WORDS)) ? WCNT_W'(r_size)
                                                              : WCNT_W'(NUM_WORDS);
    assign limit  = {lim_words, 5'd0};
    assign in_err = LIM_W'(in_end) > limit;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // mask of the range part that lies in word r_pw
    assign lo_sel = (r_pw == r_first) ? r_lo : 5'd0;
    assign hi_sel = (r_pw == r_last)  ? r_hi : 5'd31;
    assign mask   = ({bmrs_pkg::WORD_BITS{1'b1}} << lo_sel)
                  & ({bmrs_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi_sel));
    assign hit    = r_rdata & mask;
    assign iso    = hit & (~hit + 32'd1);

    always_comb begin
        hit_idx = 5'd0;
        for (int j = 0; j < bmrs_pkg::WORD_BITS; j++) begin
            if (iso[j]) begin
                hit_idx = hit_idx | 5'(j);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_first = r_first;
        n_last  = r_last;
        n_rdw   = r_rdw;
        n_more  = r_more;
        n_pv    = 1'b0;
        n_pw    = r_pw;
        n_found = r_found;
        n_fbit  = r_fbit;
        n_err   = r_err;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_rdw;
        wr_data = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_func  = in_func;
                    n_found = 1'b0;
                    n_fbit  = '1;
                    n_err   = 1'b0;
                    n_lo    = in_start[4:0];
                    n_hi    = in_endm1[4:0];
                    n_first = AW'(in_start[14:5]);
                    n_last  = AW'(in_endm1[15:5]);
                    n_rdw   = AW'(in_start[14:5]);
                    n_more  = 1'b1;
                    if (in_func == bmrs_pkg::FN_CLRALL) begin
                        n_rdw   = '0;
                        n_state = S_CLR;
                    end else if (in_err) begin
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else if (in_count == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_INIT, S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_rdw;
                n_rdw   = r_rdw + AW'(1);
                if (r_rdw == LAST_ADDR) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_OUT;
                end
            end
            S_WALK: begin
                // read word r_rdw while the word read last cycle is updated
                rd_en  = r_more;
                n_rdw  = r_rdw + AW'(1);
                n_more = r_more && (r_rdw != r_last);
                n_pv   = r_more;
                n_pw   = r_rdw;
                if (r_pv) begin
                    wr_addr = r_pw;
                    if (r_func == bmrs_pkg::FN_SET) begin
                        wr_en   = 1'b1;
                        wr_data = r_rdata | mask;
                    end else if (r_func == bmrs_pkg::FN_CLR) begin
                        wr_en   = 1'b1;
                        wr_data = r_rdata & ~mask;
                    end
                    if (r_func == bmrs_pkg::FN_FIND && hit != '0) begin
                        n_found = 1'b1;
                        n_fbit  = bmrs_pkg::FBIT_W'({r_pw, hit_idx});
                        n_state = S_OUT;
                    end else if (r_pw == r_last) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_rdw   <= '0;
            r_more  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdw   <= n_rdw;
            r_more  <= n_more;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_first <= n_first;
        r_last  <= n_last;
        r_pw    <= n_pw;
        r_found <= n_found;
        r_fbit  <= n_fbit;
        r_err   <= n_err;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_rdw];
        end
    end

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bmrs_pkg::PREG_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bmrs_pkg::SIZE_RST;
        end else if (cfg_wr) begin
            r_size <= pwdata[bmrs_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bmrs_pkg::PREG_SIZE) ? bmrs_pkg::PDATA_W'(r_size) : '0;

    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {6'd0, r_err, r_fbit, r_found};

endmodule

/* test/bmrs_checker.sv */
// Watches both stream channels and the APB port, keeps a shadow copy of the
// bitmap and the size register, and checks every result item in order.
module bmrs_checker
    import bmrs_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    input  logic                   i_pready,
    output int                     o_fail_cnt,
    output int                     o_pending
);

    // packed so that found lands in bit 0, as on o_m_tdata
    typedef struct packed {
        logic              range_error;
        logic [FBIT_W-1:0] found_bit;
        logic              found;
    } cmd_result_t;

    logic [WORD_BITS-1:0] word_store [NUM_WORDS];
    logic [SIZE_W-1:0]    size_words;
    cmd_result_t          result_q [$];
    int                   fails;

    task automatic report_mismatch(string what, int got, int want);
        if (fails < 200)
            $display("bmrs_chk: %s mismatch, got %0h want %0h", what, got, want);
        fails++;
    endtask

    // applies one command to the shadow bitmap and returns its answer
    function automatic cmd_result_t apply_cmd(t_func fn, int unsigned start,
                                              int unsigned count);
        cmd_result_t          r;
        int unsigned          words, lim, stop, w, lo, hi;
        int                   n;
        logic [WORD_BITS-1:0] m, hit;
        r.found       = 1'b0;
        r.found_bit   = '1;
        r.range_error = 1'b0;
        words = (size_words < NUM_WORDS) ? size_words : NUM_WORDS;
        lim   = words * WORD_BITS;
        stop  = start + count;
        if (fn == FN_CLRALL) begin
            for (w = 0; w < NUM_WORDS; w++)
                word_store[w] = '0;
        end else if (stop > lim) begin
            r.range_error = 1'b1;
        end else if (count != 0) begin
            for (w = start / WORD_BITS;
                 w <= (stop - 1) / WORD_BITS && w < NUM_WORDS && !r.found; w++) begin
                lo  = (start > w * WORD_BITS) ? start - w * WORD_BITS : 0;
                hi  = (stop < (w + 1) * WORD_BITS) ? stop - w * WORD_BITS : WORD_BITS;
                m   = (32'hFFFF_FFFF >> (WORD_BITS - hi)) & (32'hFFFF_FFFF << lo);
                hit = word_store[w] & m;
                if (fn == FN_SET) begin
                    word_store[w] = word_store[w] | m;
                end else if (fn == FN_CLR) begin
                    word_store[w] = word_store[w] & ~m;
                end else if (hit != '0) begin
                    r.found = 1'b1;
                    for (n = WORD_BITS - 1; n >= 0; n--)
                        if (hit[n]) r.found_bit = FBIT_W'(w * WORD_BITS + n);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cmd_result_t want, got;
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++)
                word_store[w] = '0;
            size_words = SIZE_RST;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == {PREG_SIZE, 2'b00})
                size_words = i_pwdata[SIZE_W-1:0];
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(apply_cmd(t_func'(i_s_tdata[FUNC_W-1:0]),
                                             i_s_tdata[FUNC_W +: START_W],
                                             i_s_tdata[FUNC_W+START_W +: COUNT_W]));
            if (i_m_tvalid && i_m_tready) begin
                got = cmd_result_t'(i_m_tdata[$bits(cmd_result_t)-1:0]);
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected item", int'(got), 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.found_bit !== want.found_bit)
                        report_mismatch("found_bit", got.found_bit, want.found_bit);
                    if (got.range_error !== want.range_error)
                        report_mismatch("range_error", got.range_error, want.range_error);
                end
            end
        end
        o_pending  <= result_q.size();
        o_fail_cnt <= fails;
    end

endmodule

/* test/tb_bitmap_range_set_clear_find.sv */
module tb_bitmap_range_set_clear_find;
    import bmrs_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [1:0] func, [16:2] start_bit, [32:17] bit_count, [39:33] zero
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    // [0] found, [16:1] found_bit, [17] range_error, [23:18] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [PADDR_W-1:0]     paddr      = '0;
    logic [PDATA_W-1:0]     pwdata     = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int                     fail_cnt;
    int                     pending;
    logic                   no_idle    = 1'b0;
    int unsigned            cur_size   = SIZE_RST;

    bitmap_range_set_clear_find DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bmrs_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk)
        i_m_tready <= no_idle || ($urandom_range(99) >= 11);

    task automatic push_cmd(t_func fn, int unsigned start, int unsigned count);
        if (!no_idle && $urandom_range(99) < 11) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, count[COUNT_W-1:0], start[START_W-1:0], fn};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // pending is tested only after the wait on i_clk, since the checker registers it
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_size(int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {PREG_SIZE, 2'b00};
        pwdata  <= PDATA_W'(val[SIZE_W-1:0]);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_size = val;
    endtask

    task automatic random_cmd();
        int unsigned lim, r, s, c, near;
        t_func       fn;
        lim = ((cur_size < NUM_WORDS_DEF) ? cur_size : NUM_WORDS_DEF) * WORD_BITS;
        r   = $urandom_range(99);
        fn  = (r < 32) ? FN_SET : (r < 58) ? FN_CLR : (r < 97) ? FN_FIND : FN_CLRALL;
        r   = $urandom_range(99);
        if (r < 8 || lim == 0) begin
            // noise over the whole field range, mostly out of bounds
            s = $urandom_range(32767);
            c = $urandom_range(65535);
        end else begin
            // keep half of these starts in a dense window so finds hit
            near = (lim < 2048) ? lim : 2048;
            s = ($urandom_range(1)) ? $urandom_range(near - 1) : $urandom_range(lim - 1);
            if (r < 12)
                c = $urandom_range(lim - s);
            else if (r < 16)
                c = lim - s + $urandom_range(1, 40);
            else if (r < 18)
                c = 0;
            else
                c = $urandom_range(1, 96);
        end
        push_cmd(fn, s, c);
    endtask

    initial begin
        int unsigned sizes [7];
        int unsigned counts [7];
        sizes  = '{2047, 0, 1, 37, 1023, 2, 1024};
        counts = '{250, 30, 120, 200, 250, 200, 350};
        sizes[5] = $urandom_range(2, 1022);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset size
        push_cmd(FN_FIND,   0,     32768);
        push_cmd(FN_SET,    0,     1);
        push_cmd(FN_FIND,   0,     32768);
        push_cmd(FN_SET,    32767, 1);
        push_cmd(FN_FIND,   1,     32767);
        push_cmd(FN_SET,    5,     0);
        push_cmd(FN_FIND,   0,     0);
        push_cmd(FN_SET,    32767, 2);
        push_cmd(FN_CLR,    0,     65535);
        push_cmd(FN_FIND,   32767, 0);
        push_cmd(FN_SET,    100,   70);
        push_cmd(FN_CLR,    110,   20);
        push_cmd(FN_FIND,   101,   60);
        push_cmd(FN_FIND,   110,   20);
        push_cmd(FN_FIND,   110,   40);
        push_cmd(FN_CLRALL, 32767, 65535);
        push_cmd(FN_FIND,   0,     32768);
        push_cmd(FN_SET,    0,     32768);
        push_cmd(FN_FIND,   31,    1);
        push_cmd(FN_CLR,    1,     32767);
        push_cmd(FN_FIND,   0,     32768);
        push_cmd(FN_FIND,   1,     32767);
        push_cmd(FN_CLRALL, 0,     0);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            write_size(sizes[p]);
            no_idle <= (p == 4);
            for (int k = 0; k < counts[p]; k++)
                random_cmd();
            wait_drained();
        end
        no_idle <= 1'b0;

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bmrs_pkg.sv
hdl/bitmap_range_set_clear_find.sv
test/bmrs_checker.sv
test/tb_bitmap_range_set_clear_find.sv
